// File: rtl/core/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit checker.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication that starts from a valid response.
`define CAU_ASSERT_RSP(label, cond, msg) \
    `CAU_ASSERT(label, rsp_valid |-> (cond), msg)

`endif

// File: rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit: widths, codes, stage types
// and the divider step and saturation functions. No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PW = 2 * DATA_WIDTH;              // product width
    localparam int SW = 2 * DATA_WIDTH + 1;          // signed sum width
    localparam int QB = DATA_WIDTH + 1;              // quotient bits
    localparam int NW = 2 * DATA_WIDTH + FRAC_BITS;  // scaled numerator width
    localparam int CW = 2 * DATA_WIDTH + QB;         // divider compare width

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic signed [DATA_WIDTH-1:0] POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                 is_div;
        logic                 dz;
        logic signed [SW-1:0] pre_re;
        logic signed [SW-1:0] pre_im;
    } side_t;

    typedef struct packed {
        logic          neg;
        logic [NW-1:0] num;
    } div_in_t;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [NW-1:0] rem;
        logic [QB-1:0] q;
    } div_lane_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] val;
        logic                         sat;
    } part_t;

    // One restoring step at quotient bit pos.
    function automatic div_lane_t div_step(input div_lane_t x, input logic [PW-1:0] d,
                                           input int unsigned pos);
        logic [CW-1:0] ds;
        logic [CW-1:0] r;
        div_lane_t     y;
        ds = CW'(d) << pos;
        r  = CW'(x.rem);
        y  = x;
        if (r >= ds)
        begin
            y.rem = NW'(r - ds);
            y.q   = x.q | (QB'(1) << pos);
        end
        return y;
    endfunction

    function automatic part_t sat_part(input logic signed [SW-1:0] v, input logic force_sat,
                                       input logic neg);
        part_t p;
        p.sat = 1'b1;
        if (force_sat)
            p.val = neg ? NEG_LIM : POS_LIM;
        else if (v > SW'(POS_LIM))
            p.val = POS_LIM;
        else if (v < SW'(NEG_LIM))
            p.val = NEG_LIM;
        else
        begin
            p.val = v[DATA_WIDTH-1:0];
            p.sat = 1'b0;
        end
        return p;
    endfunction

endpackage

// File: rtl/core/cau_req_if.sv
// Request channel of the complex arithmetic unit: action and two operands.
// Depends on cau_pkg.
interface cau_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
    logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
    logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
    logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;

    modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: rtl/core/cau_rsp_if.sv
// Response channel of the complex arithmetic unit: result parts and status.
// Depends on cau_pkg.
interface cau_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cau_pkg::DATA_WIDTH-1:0] res_re;
    logic signed [cau_pkg::DATA_WIDTH-1:0] res_im;
    logic [1:0]                            status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// File: rtl/core/cau_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage,
// carrying a sideband alongside. Depends on cau_pkg.
module cau_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  cau_pkg::side_t              in_side,
    input  cau_pkg::div_in_t            in_re,
    input  cau_pkg::div_in_t            in_im,
    input  logic [cau_pkg::PW-1:0]      in_d,
    output logic                        out_valid,
    output cau_pkg::side_t              out_side,
    output cau_pkg::div_lane_t          out_re,
    output cau_pkg::div_lane_t          out_im
);

    logic                   valid_reg [0:cau_pkg::QB];
    cau_pkg::side_t         side_reg  [0:cau_pkg::QB];
    cau_pkg::div_lane_t     re_reg    [0:cau_pkg::QB];
    cau_pkg::div_lane_t     im_reg    [0:cau_pkg::QB];
    logic [cau_pkg::PW-1:0] d_reg     [0:cau_pkg::QB];

    cau_pkg::div_lane_t re_next;
    cau_pkg::div_lane_t im_next;
    logic [cau_pkg::CW-1:0] d_top;

    // Quotients wider than QB bits saturate, so flag them up front.
    always_comb
    begin
        d_top       = cau_pkg::CW'(in_d) << cau_pkg::QB;
        re_next.neg = in_re.neg;
        re_next.rem = in_re.num;
        re_next.q   = '0;
        re_next.ovf = cau_pkg::CW'(in_re.num) >= d_top;
        im_next.neg = in_im.neg;
        im_next.rem = in_im.num;
        im_next.q   = '0;
        im_next.ovf = cau_pkg::CW'(in_im.num) >= d_top;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            re_reg[0]   <= re_next;
            im_reg[0]   <= im_next;
            d_reg[0]    <= in_d;
        end
    end

    for (genvar k = 0; k < cau_pkg::QB; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                d_reg[k+1]    <= d_reg[k];
                re_reg[k+1]   <= cau_pkg::div_step(re_reg[k], d_reg[k], cau_pkg::QB - 1 - k);
                im_reg[k+1]   <= cau_pkg::div_step(im_reg[k], d_reg[k], cau_pkg::QB - 1 - k);
            end
        end
    end

    assign out_valid = valid_reg[cau_pkg::QB];
    assign out_side  = side_reg[cau_pkg::QB];
    assign out_re    = re_reg[cau_pkg::QB];
    assign out_im    = im_reg[cau_pkg::QB];

endmodule

// File: rtl/core/complex_arithmetic_unit.sv
// Complex add/sub/mul/div in signed Q8.8. Pipeline: product stage,
// sum stage, 18 divider stages (range check plus one quotient bit each), output
// register; every action takes the same path. Throughput one request per cycle;
// the whole pipeline holds while a result waits. Reset clears the valid bits.
// Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_div.
module complex_arithmetic_unit
(
    input  logic  clk,
    input  logic  rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);

    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int SW = cau_pkg::SW;

    logic en;

    // Stage 1: products
    logic                 s1_valid_reg;
    logic [1:0]           s1_action_reg;
    logic                 s1_dz_reg;
    logic signed [PW-1:0] s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg;
    logic signed [PW-1:0] s1_br2_reg, s1_bi2_reg;
    logic signed [SW-1:0] s1_as_re_reg, s1_as_im_reg;

    // Stage 2: sums
    logic                 s2_valid_reg;
    cau_pkg::side_t       s2_side_reg, s2_side_next;
    cau_pkg::div_in_t     s2_re_reg, s2_re_next, s2_im_reg, s2_im_next;
    logic [PW-1:0]        s2_d_reg, s2_d_next;

    logic signed [SW-1:0] mul_re, mul_im, n_re, n_im;
    logic [SW-1:0]        mag_re, mag_im, mag_nre, mag_nim;

    // Divider outputs
    logic                 dv_valid;
    cau_pkg::side_t       dv_side;
    cau_pkg::div_lane_t   dv_re, dv_im;

    logic signed [SW-1:0] v_re, v_im;
    cau_pkg::part_t       p_re, p_im;

    logic                 out_valid_reg;
    logic signed [DW-1:0] out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic [1:0]           out_status_reg, out_status_next;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= req.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_action_reg <= req.action;
            s1_dz_reg     <= (req.b_re == '0) && (req.b_im == '0);
            s1_rr_reg     <= PW'(req.a_re) * PW'(req.b_re);
            s1_ii_reg     <= PW'(req.a_im) * PW'(req.b_im);
            s1_ri_reg     <= PW'(req.a_re) * PW'(req.b_im);
            s1_ir_reg     <= PW'(req.a_im) * PW'(req.b_re);
            s1_br2_reg    <= PW'(req.b_re) * PW'(req.b_re);
            s1_bi2_reg    <= PW'(req.b_im) * PW'(req.b_im);
            if (req.action == cau_pkg::ACT_SUB)
            begin
                s1_as_re_reg <= SW'(req.a_re) - SW'(req.b_re);
                s1_as_im_reg <= SW'(req.a_im) - SW'(req.b_im);
            end
            else
            begin
                s1_as_re_reg <= SW'(req.a_re) + SW'(req.b_re);
                s1_as_im_reg <= SW'(req.a_im) + SW'(req.b_im);
            end
            s2_side_reg   <= s2_side_next;
            s2_re_reg     <= s2_re_next;
            s2_im_reg     <= s2_im_next;
            s2_d_reg      <= s2_d_next;
            out_re_reg    <= out_re_next;
            out_im_reg    <= out_im_next;
            out_status_reg <= out_status_next;
        end
    end

    // Stage 2: truncate multiply results toward zero, form divide numerators and divisor.
    always_comb
    begin
        mul_re  = SW'(s1_rr_reg) - SW'(s1_ii_reg);
        mul_im  = SW'(s1_ri_reg) + SW'(s1_ir_reg);
        n_re    = SW'(s1_rr_reg) + SW'(s1_ii_reg);
        n_im    = SW'(s1_ir_reg) - SW'(s1_ri_reg);
        mag_re  = mul_re[SW-1] ? SW'(-mul_re) : SW'(mul_re);
        mag_im  = mul_im[SW-1] ? SW'(-mul_im) : SW'(mul_im);
        mag_nre = n_re[SW-1] ? SW'(-n_re) : SW'(n_re);
        mag_nim = n_im[SW-1] ? SW'(-n_im) : SW'(n_im);

        s2_side_next.is_div = 1'b0;
        s2_side_next.dz     = s1_dz_reg;
        case (s1_action_reg)
            cau_pkg::ACT_MUL:
            begin
                s2_side_next.pre_re = mul_re[SW-1] ? -$signed(mag_re >> cau_pkg::FRAC_BITS)
                                                   : $signed(mag_re >> cau_pkg::FRAC_BITS);
                s2_side_next.pre_im = mul_im[SW-1] ? -$signed(mag_im >> cau_pkg::FRAC_BITS)
                                                   : $signed(mag_im >> cau_pkg::FRAC_BITS);
            end
            cau_pkg::ACT_DIV:
            begin
                s2_side_next.is_div = 1'b1;
                s2_side_next.pre_re = '0;
                s2_side_next.pre_im = '0;
            end
            default:
            begin
                s2_side_next.pre_re = s1_as_re_reg;
                s2_side_next.pre_im = s1_as_im_reg;
            end
        endcase

        s2_re_next.neg = n_re[SW-1];
        s2_re_next.num = {mag_nre[PW-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
        s2_im_next.neg = n_im[SW-1];
        s2_im_next.num = {mag_nim[PW-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
        s2_d_next      = PW'($unsigned(s1_br2_reg)) + PW'($unsigned(s1_bi2_reg));
    end

    cau_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_side   (s2_side_reg),
        .in_re     (s2_re_reg),
        .in_im     (s2_im_reg),
        .in_d      (s2_d_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_re    (dv_re),
        .out_im    (dv_im)
    );

    // Output stage: apply sign to quotients, saturate, pick status.
    always_comb
    begin
        v_re = dv_side.pre_re;
        v_im = dv_side.pre_im;
        if (dv_side.is_div)
        begin
            v_re = dv_re.neg ? -$signed(SW'(dv_re.q)) : $signed(SW'(dv_re.q));
            v_im = dv_im.neg ? -$signed(SW'(dv_im.q)) : $signed(SW'(dv_im.q));
        end
        p_re = cau_pkg::sat_part(v_re, dv_side.is_div && dv_re.ovf, dv_re.neg);
        p_im = cau_pkg::sat_part(v_im, dv_side.is_div && dv_im.ovf, dv_im.neg);
        out_re_next = p_re.val;
        out_im_next = p_im.val;
        out_status_next = (p_re.sat || p_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (dv_side.is_div && dv_side.dz)
        begin
            out_re_next     = '0;
            out_im_next     = '0;
            out_status_next = cau_pkg::ST_DZ;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.res_re = out_re_reg;
    assign rsp.res_im = out_im_reg;
    assign rsp.status = out_status_reg;

endmodule

// File: rtl/core/cau_checker.sv
// Port-level checker for the complex arithmetic unit and its bind.
// Depends on cau_pkg and complex_arithmetic_unit_assert.svh.
`include "complex_arithmetic_unit_assert.svh"

module cau_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic signed [cau_pkg::DATA_WIDTH-1:0] res_re,
    input logic signed [cau_pkg::DATA_WIDTH-1:0] res_im,
    input logic [1:0]                            status
);

    `CAU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
    `CAU_ASSERT_RSP(a_status_code, status == cau_pkg::ST_OK || status == cau_pkg::ST_SAT || status == cau_pkg::ST_DZ, "bad status code")
    `CAU_ASSERT_RSP(a_dz_zero, status != cau_pkg::ST_DZ || (res_re == '0 && res_im == '0), "divide by zero with nonzero parts")
    `CAU_ASSERT_RSP(a_sat_limit, status != cau_pkg::ST_SAT || res_re == cau_pkg::POS_LIM || res_re == cau_pkg::NEG_LIM || res_im == cau_pkg::POS_LIM || res_im == cau_pkg::NEG_LIM, "saturation without limit value")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_re    (rsp.res_re),
    .res_im    (rsp.res_im),
    .status    (rsp.status)
);
